@@ sv/pvenc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pvenc_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned NumBytes   = ValueWidth / ByteWidth;
  localparam int unsigned GroupBits  = 7;

  typedef logic [3:0] cnt_t;
  typedef logic [2:0] sel_t;
  typedef logic [ByteWidth-1:0] byte_t;

  localparam cnt_t  EscCount = cnt_t'(NumBytes);
  localparam byte_t EscByte  = 8'hff;

  function automatic byte_t prefix_byte(input sel_t k);
    logic [15:0] wide;
    wide = 16'hff00 >> k;
    return wide[7:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/prefix_varint_encoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Prefix-length varint encoder. Each request carries one 64-bit unsigned
// value and produces 1 to 9 bytes on the output channel, first byte first,
// with last_o set on the final byte. A value below 2^(7*(k+1)) for k in 0..7
// takes 1+k bytes: k leading ones, a zero and the top payload bits in the
// first byte, the rest big-endian. Larger values give 0xff and then the eight
// value bytes least significant first. The block emits one byte per cycle
// while the output is not stalled; the next request is taken in the cycle
// the previous value's last byte enters the output register, so values
// stream without gaps when not stalled. An accepted request is first held
// in the value register, and its first byte then enters the output register.
module prefix_varint_encoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  logic [63:0]         value_q;
  pvenc_pkg::cnt_t     len_q, len_d;
  pvenc_pkg::cnt_t     idx_q;
  logic                busy_q;
  logic                out_valid_q;
  pvenc_pkg::byte_t    out_byte_q, out_byte_d;
  logic                last_q;

  logic                out_free, cur_last, advance, in_ready, accept;
  pvenc_pkg::cnt_t     sel_wide;
  pvenc_pkg::sel_t     sel;
  pvenc_pkg::byte_t    data_byte;

  always_comb begin
    len_d = pvenc_pkg::EscCount;
    for (int j = 7; j >= 0; j--) begin
      if ((value_i >> (pvenc_pkg::GroupBits * (j + 1))) == 64'd0) begin
        len_d = pvenc_pkg::cnt_t'(j);
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign cur_last = (idx_q == len_q);
  assign advance  = busy_q && out_free;
  assign in_ready = !busy_q || (advance && cur_last);
  assign accept   = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;

  always_comb begin
    if (idx_q == 4'd0) begin
      sel_wide = len_q;
    end else if (len_q == pvenc_pkg::EscCount) begin
      sel_wide = idx_q - 4'd1;
    end else begin
      sel_wide = len_q - idx_q;
    end
    sel       = sel_wide[2:0];
    data_byte = value_q[{sel, 3'b000} +: 8];
    if (idx_q != 4'd0) begin
      out_byte_d = data_byte;
    end else if (len_q == pvenc_pkg::EscCount) begin
      out_byte_d = pvenc_pkg::EscByte;
    end else begin
      out_byte_d = pvenc_pkg::prefix_byte(len_q[2:0]) | data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (advance) begin
        idx_q <= idx_q + 4'd1;
        if (cur_last) begin
          busy_q <= 1'b0;
        end
      end
      if (out_free) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= value_i;
      len_q   <= len_d;
    end
    if (advance) begin
      out_byte_q <= out_byte_d;
      last_q     <= cur_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
